>>> src/sgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared constants and the command word passed from the front end to the
// back end of the SGR attribute interpreter.
// ----------------------------------------------------------------------------
package sgr_pkg;

	localparam int SGR_PALETTE_DEPTH = 256;
	localparam int COLOR_W           = 24;
	localparam int QUEUE_DEPTH       = 2;
	localparam int NUM_FLAGS         = 6;

	localparam logic [1:0] KIND_PARAM = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_PAL   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNSUP   = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	localparam logic [1:0] SRC_KEEP   = 2'd0;
	localparam logic [1:0] SRC_PAL_A  = 2'd1;
	localparam logic [1:0] SRC_PAL_B  = 2'd2;
	localparam logic [1:0] SRC_DIRECT = 2'd3;

	localparam int ATTR_BOLD   = 0;
	localparam int ATTR_FAINT  = 1;
	localparam int ATTR_ITALIC = 2;
	localparam int ATTR_UNDER  = 3;
	localparam int ATTR_STRIKE = 4;
	localparam int ATTR_INV    = 5;

	typedef struct packed {
		logic                 pal_wr;
		logic [7:0]           addr_a;
		logic [7:0]           addr_b;
		logic [1:0]           fg_src;
		logic [1:0]           bg_src;
		logic [COLOR_W-1:0]   rgb;
		logic [NUM_FLAGS-1:0] flag_set;
		logic [NUM_FLAGS-1:0] flag_clr;
		logic [1:0]           status;
	} sgr_cmd_t;

endpackage
`default_nettype wire

>>> src/sgr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_ifs
// Valid/ready channels for input words and for rendition result words.
// ----------------------------------------------------------------------------
interface sgr_in_if import sgr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [15:0]        param_value;
	logic               first_param;
	logic               last_param;
	logic [7:0]         palette_slot;
	logic [COLOR_W-1:0] palette_color;

	modport source(output valid, output kind, output param_value, output first_param,
		output last_param, output palette_slot, output palette_color, input ready);
	modport sink(input valid, input kind, input param_value, input first_param,
		input last_param, input palette_slot, input palette_color, output ready);
endinterface

interface sgr_out_if import sgr_pkg::*;;
	logic               valid;
	logic               ready;
	logic               bold;
	logic               faint;
	logic               italic;
	logic               underline;
	logic               strikeout;
	logic               inverse;
	logic [COLOR_W-1:0] fg_color;
	logic [COLOR_W-1:0] bg_color;
	logic [1:0]         status;

	modport source(output valid, output bold, output faint, output italic,
		output underline, output strikeout, output inverse, output fg_color,
		output bg_color, output status, input ready);
	modport sink(input valid, input bold, input faint, input italic,
		input underline, input strikeout, input inverse, input fg_color,
		input bg_color, input status, output ready);
endinterface
`default_nettype wire

>>> src/sgr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_ram
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sgr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem_q[raddr_a];
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule
`default_nettype wire

>>> src/sgr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_front
// Accepts input words, tracks the extended color sub-parameter state and
// turns each word into a command for the back end.
// ----------------------------------------------------------------------------
module sgr_front import sgr_pkg::*; #(
	parameter int PALETTE_DEPTH = SGR_PALETTE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sgr_in_if.sink    sgr,
	input  wire logic full,
	output logic      push,
	output sgr_cmd_t  cmd
);

	localparam logic [2:0] SUB_NONE = 3'd0;
	localparam logic [2:0] SUB_SEL  = 3'd1;
	localparam logic [2:0] SUB_IDX  = 3'd2;
	localparam logic [2:0] SUB_RED  = 3'd3;
	localparam logic [2:0] SUB_GRN  = 3'd4;
	localparam logic [2:0] SUB_BLU  = 3'd5;

	localparam logic [15:0] OMITTED   = 16'hFFFF;
	localparam logic [15:0] DEPTH_V   = 16'(PALETTE_DEPTH);
	localparam logic [8:0]  DEPTH_S   = 9'(PALETTE_DEPTH);

	logic [2:0]  sub_mode_q, sub_mode_d, eff_mode;
	logic        tgt_bg_q, tgt_bg_d;
	logic [7:0]  red_q, red_d;
	logic [7:0]  green_q, green_d;
	logic [15:0] v;
	logic [15:0] idx;
	logic [7:0]  lo;

	assign v        = sgr.param_value;
	assign lo       = sgr.param_value[7:0];
	assign idx      = (v == OMITTED) ? 16'd0 : v;
	assign eff_mode = sgr.first_param ? SUB_NONE : sub_mode_q;

	assign sgr.ready = !full;
	assign push      = sgr.valid && !full;

	always_comb begin
		cmd        = '0;
		sub_mode_d = sub_mode_q;
		tgt_bg_d   = tgt_bg_q;
		red_d      = red_q;
		green_d    = green_q;
		case (sgr.kind)
			KIND_EMPTY: begin
				sub_mode_d   = SUB_NONE;
				cmd.fg_src   = SRC_PAL_A;
				cmd.addr_a   = 8'd15;
				cmd.bg_src   = SRC_PAL_B;
				cmd.addr_b   = 8'd0;
				cmd.flag_clr = '1;
			end
			KIND_PAL: begin
				cmd.pal_wr = {1'b0, sgr.palette_slot} < DEPTH_S;
				cmd.addr_a = sgr.palette_slot;
				cmd.rgb    = sgr.palette_color;
			end
			KIND_PARAM: begin
				sub_mode_d = eff_mode;
				if (sgr.first_param && sgr.last_param && v == 16'd0) begin
					sub_mode_d   = SUB_NONE;
					cmd.fg_src   = SRC_PAL_A;
					cmd.addr_a   = 8'd15;
					cmd.bg_src   = SRC_PAL_B;
					cmd.addr_b   = 8'd0;
					cmd.flag_clr = '1;
				end else begin
					case (eff_mode)
						SUB_SEL: begin
							if (v == 16'd5) begin
								sub_mode_d = SUB_IDX;
							end else if (v == 16'd2) begin
								sub_mode_d = SUB_RED;
							end else begin
								sub_mode_d = SUB_NONE;
								cmd.status = ST_UNSUP;
							end
						end
						SUB_IDX: begin
							sub_mode_d = SUB_NONE;
							if (idx > 16'd255 || idx >= DEPTH_V) begin
								cmd.status = ST_RANGE;
							end else begin
								cmd.addr_a = idx[7:0];
								if (tgt_bg_q) begin
									cmd.bg_src = SRC_PAL_A;
								end else begin
									cmd.fg_src = SRC_PAL_A;
								end
							end
						end
						SUB_RED, SUB_GRN, SUB_BLU: begin
							if (v > 16'd255) begin
								sub_mode_d = SUB_NONE;
								cmd.status = ST_RANGE;
							end else if (eff_mode == SUB_RED) begin
								red_d      = lo;
								sub_mode_d = SUB_GRN;
							end else if (eff_mode == SUB_GRN) begin
								green_d    = lo;
								sub_mode_d = SUB_BLU;
							end else begin
								sub_mode_d = SUB_NONE;
								cmd.rgb    = {red_q, green_q, lo};
								if (tgt_bg_q) begin
									cmd.bg_src = SRC_DIRECT;
								end else begin
									cmd.fg_src = SRC_DIRECT;
								end
							end
						end
						default: begin
							sub_mode_d = SUB_NONE;
							if (v == 16'd1) begin
								cmd.flag_set[ATTR_BOLD] = 1'b1;
							end else if (v == 16'd2) begin
								cmd.flag_set[ATTR_FAINT] = 1'b1;
							end else if (v == 16'd3) begin
								cmd.flag_set[ATTR_ITALIC] = 1'b1;
							end else if (v == 16'd4) begin
								cmd.flag_set[ATTR_UNDER] = 1'b1;
							end else if (v == 16'd7) begin
								cmd.flag_set[ATTR_INV] = 1'b1;
							end else if (v == 16'd22) begin
								cmd.flag_clr[ATTR_BOLD]  = 1'b1;
								cmd.flag_clr[ATTR_FAINT] = 1'b1;
							end else if (v == 16'd23) begin
								cmd.flag_clr[ATTR_ITALIC] = 1'b1;
							end else if (v == 16'd24) begin
								cmd.flag_clr[ATTR_UNDER] = 1'b1;
							end else if (v == 16'd27) begin
								cmd.flag_clr[ATTR_INV] = 1'b1;
							end else if (v >= 16'd30 && v <= 16'd37) begin
								cmd.fg_src = SRC_PAL_A;
								cmd.addr_a = lo - 8'd30;
							end else if (v == 16'd38) begin
								tgt_bg_d   = 1'b0;
								sub_mode_d = SUB_SEL;
							end else if (v == 16'd39) begin
								cmd.fg_src = SRC_PAL_A;
								cmd.addr_a = 8'd15;
							end else if (v >= 16'd40 && v <= 16'd47) begin
								cmd.bg_src = SRC_PAL_A;
								cmd.addr_a = lo - 8'd40;
							end else if (v == 16'd48) begin
								tgt_bg_d   = 1'b1;
								sub_mode_d = SUB_SEL;
							end else if (v == 16'd49) begin
								cmd.bg_src = SRC_PAL_A;
								cmd.addr_a = 8'd0;
							end else if (v >= 16'd90 && v <= 16'd97) begin
								cmd.fg_src = SRC_PAL_A;
								cmd.addr_a = lo - 8'd82;
							end else if (v >= 16'd100 && v <= 16'd107) begin
								cmd.bg_src = SRC_PAL_A;
								cmd.addr_a = lo - 8'd92;
							end else if (v == 16'd5 || v == 16'd6 || v == 16'd25
								|| v == 16'd26 || v == 16'd28 || v == 16'd29
								|| (v >= 16'd8 && v <= 16'd21)
								|| (v >= 16'd50 && v <= 16'd89)
								|| v == 16'd98 || v == 16'd99) begin
								cmd.status = ST_UNSUP;
							end
						end
					endcase
				end
				if (sgr.last_param && sub_mode_d != SUB_NONE) begin
					if (cmd.status == ST_OK) begin
						cmd.status = ST_MISSING;
					end
					sub_mode_d = SUB_NONE;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_mode_q <= SUB_NONE;
			tgt_bg_q   <= 1'b0;
			red_q      <= '0;
			green_q    <= '0;
		end else if (push) begin
			sub_mode_q <= sub_mode_d;
			tgt_bg_q   <= tgt_bg_d;
			red_q      <= red_d;
			green_q    <= green_d;
		end
	end

endmodule
`default_nettype wire

>>> src/sgr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sgr_queue import sgr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire sgr_cmd_t cmd_in,
	output logic          full,
	output logic          valid,
	input  wire logic     pop,
	output sgr_cmd_t      cmd_out
);

	localparam int QAW = $clog2(QUEUE_DEPTH);

	sgr_cmd_t       entry_q [QUEUE_DEPTH];
	logic [QAW:0]   wptr_q;
	logic [QAW:0]   rptr_q;

	assign valid   = wptr_q != rptr_q;
	assign full    = (wptr_q[QAW] != rptr_q[QAW]) && (wptr_q[QAW-1:0] == rptr_q[QAW-1:0]);
	assign cmd_out = entry_q[rptr_q[QAW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q[QAW-1:0]] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/sgr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_back
// Executes commands: palette writes and reads, then updates the rendition
// state and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module sgr_back import sgr_pkg::*; #(
	parameter int PALETTE_DEPTH = SGR_PALETTE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_valid,
	input  wire sgr_cmd_t q_cmd,
	output logic          pop,
	sgr_out_if.source     rend
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic                 valid_s1;
	sgr_cmd_t             cmd_s1;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [NUM_FLAGS-1:0] flags_q;
	logic [COLOR_W-1:0]   fg_q, bg_q;
	logic [COLOR_W-1:0]   fg_d, bg_d;
	logic [COLOR_W-1:0]   rdata_a, rdata_b;
	logic                 out_free;
	logic                 adv_s1;

	assign out_free = !out_valid_q || rend.ready;
	assign adv_s1   = valid_s1 && out_free;
	assign pop      = q_valid && (!valid_s1 || adv_s1);

	sgr_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk    (clk),
		.we     (pop && q_cmd.pal_wr),
		.waddr  (q_cmd.addr_a[AW-1:0]),
		.wdata  (q_cmd.rgb),
		.re     (pop),
		.raddr_a(q_cmd.addr_a[AW-1:0]),
		.raddr_b(q_cmd.addr_b[AW-1:0]),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_comb begin
		case (cmd_s1.fg_src)
			SRC_PAL_A:  fg_d = rdata_a;
			SRC_PAL_B:  fg_d = rdata_b;
			SRC_DIRECT: fg_d = cmd_s1.rgb;
			default:    fg_d = fg_q;
		endcase
		case (cmd_s1.bg_src)
			SRC_PAL_A:  bg_d = rdata_a;
			SRC_PAL_B:  bg_d = rdata_b;
			SRC_DIRECT: bg_d = cmd_s1.rgb;
			default:    bg_d = bg_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			flags_q     <= '0;
			fg_q        <= '0;
			bg_q        <= '0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				status_q    <= cmd_s1.status;
				flags_q     <= (flags_q & ~cmd_s1.flag_clr) | cmd_s1.flag_set;
				fg_q        <= fg_d;
				bg_q        <= bg_d;
			end else if (rend.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rend.valid     = out_valid_q;
	assign rend.bold      = flags_q[ATTR_BOLD];
	assign rend.faint     = flags_q[ATTR_FAINT];
	assign rend.italic    = flags_q[ATTR_ITALIC];
	assign rend.underline = flags_q[ATTR_UNDER];
	assign rend.strikeout = flags_q[ATTR_STRIKE];
	assign rend.inverse   = flags_q[ATTR_INV];
	assign rend.fg_color  = fg_q;
	assign rend.bg_color  = bg_q;
	assign rend.status    = status_q;

endmodule
`default_nettype wire

>>> src/sgr_attribute_interpreter.sv
// ----------------------------------------------------------------------------
// sgr_attribute_interpreter
// A word passes through the command queue, the palette read stage and the result register in turn.
// Throughput: one word per cycle unless the result sink holds off ready; the palette RAM is read once per word.
// Reset clears flags, colors and the sub-parameter state; the palette is
// left unwritten and no clearing pass runs, so words are taken right away.
// SGR rendition state with a 256-entry palette, built as a classifying
// front end, a short command queue and an executing back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sgr_attribute_interpreter import sgr_pkg::*; #(
	parameter int PALETTE_DEPTH = SGR_PALETTE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sgr_in_if.sink    sgr,
	sgr_out_if.source rend
);

	logic     push;
	logic     full;
	logic     q_valid;
	logic     pop;
	sgr_cmd_t f_cmd;
	sgr_cmd_t q_cmd;

	sgr_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.sgr   (sgr),
		.full  (full),
		.push  (push),
		.cmd   (f_cmd)
	);

	sgr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (f_cmd),
		.full   (full),
		.valid  (q_valid),
		.pop    (pop),
		.cmd_out(q_cmd)
	);

	sgr_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_cmd  (q_cmd),
		.pop    (pop),
		.rend   (rend)
	);

	a_no_strikeout: assert property (@(posedge clk) disable iff (!arst_n)
		!rend.strikeout)
		else $error("strikeout flag was set");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> q_valid)
		else $error("pushed command missing from queue");

endmodule
`default_nettype wire
